FILE: hdl/box_filter_mipmap_builder_macros.svh
// Assertion macros shared by the mipmap builder RTL.
`ifndef BOX_FILTER_MIPMAP_BUILDER_MACROS_SVH
`define BOX_FILTER_MIPMAP_BUILDER_MACROS_SVH

`ifndef ASSERT_OFF
`define BFM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bfm assertion failed");
`define BFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bfm assertion failed");
`else
`define BFM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BFM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/bfm_pkg.sv
// Package with the constants, types and codes of the mipmap builder.
`default_nettype none
package bfm_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_LEVEL  = 8;

  localparam int X_W        = 8;
  localparam int Y_W        = 8;
  localparam int LVL_W      = 4;
  localparam int DIM_W      = 9;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 4;
  localparam int PIX_W      = CH_W * NUM_CH;

  localparam int NUM_LANES  = 4;
  localparam int LANE_W     = $clog2(NUM_LANES);
  localparam int BANK_AW    = Y_W + X_W - LANE_W;

  localparam int SUM_W      = CH_W + 2 * MAX_LEVEL;
  localparam int LANE_SUM_W = SUM_W - LANE_W;
  localparam int CNT_W      = MAX_LEVEL;
  localparam int GRP_W      = MAX_LEVEL - LANE_W;
  localparam int SHIFT_W    = LVL_W + 1;

  typedef enum logic [1:0] {
    CFG_WIDTH     = 2'd0,
    CFG_HEIGHT    = 2'd1,
    CFG_CHANNELS  = 2'd2,
    CFG_TOP_LEVEL = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_COMPUTE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic               en;
    logic [BANK_AW-1:0] addr;
    logic [PIX_W-1:0]   data;
  } wr_t;

  typedef struct packed {
    logic               en;
    logic               clear;
    logic [BANK_AW-1:0] addr;
  } rd_t;

  typedef logic [NUM_CH-1:0][LANE_SUM_W-1:0] lane_sum_t;
  typedef logic [NUM_CH-1:0][CH_W-1:0]       avg_t;

endpackage
`default_nettype wire

FILE: hdl/bfm_if.sv
// Request and result channel interfaces of the mipmap builder.
`default_nettype none
interface bfm_req_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic [3:0] mip_level;
  logic [7:0] chan0;
  logic [7:0] chan1;
  logic [7:0] chan2;
  logic [7:0] chan3;

  modport source (output valid, opcode, pos_x, pos_y, mip_level, chan0, chan1, chan2, chan3,
                  input ready);
  modport sink (input valid, opcode, pos_x, pos_y, mip_level, chan0, chan1, chan2, chan3,
                output ready);
endinterface

interface bfm_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] out_level;
  logic [7:0] out_x;
  logic [7:0] out_y;
  logic [7:0] avg0;
  logic [7:0] avg1;
  logic [7:0] avg2;
  logic [7:0] avg3;
  logic       status;

  modport source (output valid, out_level, out_x, out_y, avg0, avg1, avg2, avg3, status,
                  input ready);
  modport sink (input valid, out_level, out_x, out_y, avg0, avg1, avg2, avg3, status,
                output ready);
endinterface
`default_nettype wire

FILE: hdl/bfm_lane.sv
// One lane: a bank of the base image and per-channel window accumulators.
`default_nettype none
module bfm_lane
  import bfm_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire wr_t       wr_i,
  input  wire rd_t       rd_i,
  input  wire logic      lane_en_i,
  output lane_sum_t      sum_o
);

  // Columns whose low bits match this lane live here.
  logic [PIX_W-1:0] mem_q [2**BANK_AW];
  logic [PIX_W-1:0] rdata_q;
  logic             rvalid_q;
  lane_sum_t        acc_q, acc_d;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= rd_i.en & lane_en_i;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      acc_d[c] = acc_q[c] + LANE_SUM_W'(rdata_q[c*CH_W +: CH_W]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.clear) begin
      acc_q <= '0;
    end else if (rvalid_q) begin
      acc_q <= acc_d;
    end
  end

  assign sum_o = acc_q;

endmodule
`default_nettype wire

FILE: hdl/bfm_merge.sv
// Merge stage: adds the lane sums per channel and divides by the window area.
`default_nettype none
module bfm_merge
  import bfm_pkg::*;
(
  input  wire lane_sum_t        sums_i [NUM_LANES],
  input  wire logic [LVL_W-1:0] lvl_i,
  output avg_t                  avg_o
);

  logic [SUM_W-1:0]   total;
  logic [SUM_W-1:0]   shifted;
  logic [SHIFT_W-1:0] shamt;

  assign shamt = {lvl_i, 1'b0};

  always_comb begin
    avg_o   = '0;
    total   = '0;
    shifted = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      total = '0;
      for (int l = 0; l < NUM_LANES; l++) begin
        total = total + SUM_W'(sums_i[l][c]);
      end
      shifted  = total >> shamt;
      avg_o[c] = shifted[CH_W-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/box_filter_mipmap_builder.sv
// Top level of the box-filter mipmap builder.
`default_nettype none
`include "box_filter_mipmap_builder_macros.svh"
// The block holds a 256x256 base image of 32-bit pixels, split over four
// banks by the two low column bits, each bank 16384 words deep with one
// read lane. A load request writes one pixel and returns nothing; a new
// request is taken in the next cycle. A compute request for level L walks
// the 2^L by 2^L window row by row, reading four adjacent pixels per cycle
// through the four lanes; the bank read port sets the length of the walk.
// A request with a level or a position out of range skips the walk and
// returns status 1 with zero averages. Requests are taken one at a time;
// the result sits in an output register, so the next request is taken
// while the result waits. Pixels that were never loaded read as unknown
// data. The user must write configuration through the plain write port
// only while no compute request is in flight; the block itself does not
// enforce this.
module box_filter_mipmap_builder
  import bfm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  bfm_req_if.sink         req_i,
  bfm_res_if.source       res_o,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [8:0] cfg_data_i
);

  // Configuration registers.
  logic [DIM_W-1:0] width_q, height_q;
  logic [2:0]       chans_q;
  logic [LVL_W-1:0] top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(MAX_WIDTH);
      height_q <= DIM_W'(MAX_HEIGHT);
      chans_q  <= 3'd4;
      top_q    <= LVL_W'(MAX_LEVEL);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:     width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_HEIGHT:    height_q <= cfg_data_i[DIM_W-1:0];
        CFG_CHANNELS:  chans_q  <= cfg_data_i[2:0];
        CFG_TOP_LEVEL: top_q    <= cfg_data_i[LVL_W-1:0];
        default:       top_q    <= top_q;
      endcase
    end
  end

  // Effective limits: oversized dimensions and levels are clamped.
  logic [DIM_W-1:0] eff_w, eff_h, lvl_w, lvl_h;
  logic [LVL_W-1:0] lvl_limit;
  logic             three_ch;

  assign eff_w     = (width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q;
  assign eff_h     = (height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q;
  assign lvl_limit = (top_q < LVL_W'(MAX_LEVEL)) ? top_q : LVL_W'(MAX_LEVEL);
  assign three_ch  = (chans_q == 3'd3);
  assign lvl_w     = eff_w >> req_i.mip_level;
  assign lvl_h     = eff_h >> req_i.mip_level;

  // Request decode.
  logic in_ready, in_fire, is_compute, req_err;
  logic [X_W-1:0] cx_new;
  logic [Y_W-1:0] cy_new;
  logic [NUM_LANES-1:0] lane_en_new;

  assign in_fire    = req_i.valid & in_ready;
  assign is_compute = (op_e'(req_i.opcode) == OP_COMPUTE);
  assign req_err    = (req_i.mip_level > lvl_limit)
                   || (DIM_W'(req_i.pos_x) >= lvl_w)
                   || (DIM_W'(req_i.pos_y) >= lvl_h);
  // The corner fits in the position width whenever the request is in range.
  assign cx_new = req_i.pos_x << req_i.mip_level;
  assign cy_new = req_i.pos_y << req_i.mip_level;

  // Windows narrower than the lane count use only the lanes they cover.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      lane_en_new[i] = ((LANE_W'(i) >> req_i.mip_level)
                     == (cx_new[LANE_W-1:0] >> req_i.mip_level));
    end
  end

  // Sequencer state.
  state_e             st_q, st_d;
  logic [CNT_W-1:0]   yy_q;
  logic [GRP_W-1:0]   gg_q;
  logic [LVL_W-1:0]   lvl_q;
  logic [X_W-1:0]     x_q, cx_q;
  logic [Y_W-1:0]     y_q, cy_q;
  logic               err_q;
  logic [NUM_LANES-1:0] lane_en_q;

  logic [CNT_W-1:0] row_last;
  logic [GRP_W-1:0] grp_last;
  logic             row_done, last_issue;
  logic             out_free, out_load;
  logic             out_valid_q;

  assign row_last   = ~({CNT_W{1'b1}} << lvl_q);
  assign grp_last   = GRP_W'(row_last >> LANE_W);
  assign row_done   = (gg_q == grp_last);
  assign last_issue = row_done && (yy_q == row_last);
  assign out_free   = !out_valid_q || res_o.ready;

  // Next state.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (in_fire && is_compute) begin
          st_d = req_err ? ST_FINISH : ST_READ;
        end
      end
      ST_READ: begin
        if (last_issue) begin
          st_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        st_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer. The accumulators clear as a compute request
  // is taken, which only happens while idle.
  rd_t rd;
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    rd.en    = 1'b0;
    rd.clear = req_i.valid && (st_q == ST_IDLE) && is_compute;
    rd.addr  = {cy_q + Y_W'(yy_q), cx_q[X_W-1:LANE_W] + (X_W-LANE_W)'(gg_q)};
    unique case (st_q)
      ST_IDLE:   in_ready = 1'b1;
      ST_READ:   rd.en    = 1'b1;
      ST_DRAIN:  rd.en    = 1'b0;
      ST_FINISH: out_load = out_free;
      default:   in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      yy_q <= '0;
      gg_q <= '0;
    end else begin
      st_q <= st_d;
      if (in_fire) begin
        yy_q <= '0;
        gg_q <= '0;
      end else if (st_q == ST_READ) begin
        if (row_done) begin
          gg_q <= '0;
          yy_q <= yy_q + CNT_W'(1);
        end else begin
          gg_q <= gg_q + GRP_W'(1);
        end
      end
    end
  end

  // Request context, held for the whole walk.
  always_ff @(posedge clk_i) begin
    if (in_fire && is_compute) begin
      lvl_q     <= req_i.mip_level;
      x_q       <= req_i.pos_x;
      y_q       <= req_i.pos_y;
      cx_q      <= cx_new;
      cy_q      <= cy_new;
      err_q     <= req_err;
      lane_en_q <= lane_en_new;
    end
  end

  // Lanes: load requests go to the bank that owns the column.
  lane_sum_t lane_sum [NUM_LANES];

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    wr_t wr;
    assign wr.en   = in_fire && !is_compute && (req_i.pos_x[LANE_W-1:0] == LANE_W'(i));
    assign wr.addr = {req_i.pos_y, req_i.pos_x[X_W-1:LANE_W]};
    assign wr.data = {req_i.chan3, req_i.chan2, req_i.chan1, req_i.chan0};

    bfm_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .wr_i      (wr),
      .rd_i      (rd),
      .lane_en_i (lane_en_q[i]),
      .sum_o     (lane_sum[i])
    );
  end

  avg_t merged;

  bfm_merge u_merge (
    .sums_i (lane_sum),
    .lvl_i  (lvl_q),
    .avg_o  (merged)
  );

  // Output register.
  logic [LVL_W-1:0] out_level_q;
  logic [X_W-1:0]   out_x_q;
  logic [Y_W-1:0]   out_y_q;
  avg_t             out_avg_q, out_avg_d;
  logic             out_status_q;

  // Error results and the fourth channel of a three-channel image read zero.
  always_comb begin
    out_avg_d = err_q ? '0 : merged;
    if (err_q || three_ch) begin
      out_avg_d[3] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_level_q  <= lvl_q;
      out_x_q      <= x_q;
      out_y_q      <= y_q;
      out_status_q <= err_q;
      out_avg_q    <= out_avg_d;
    end
  end

  assign req_i.ready     = in_ready;
  assign res_o.valid     = out_valid_q;
  assign res_o.out_level = out_level_q;
  assign res_o.out_x     = out_x_q;
  assign res_o.out_y     = out_y_q;
  assign res_o.avg0      = out_avg_q[0];
  assign res_o.avg1      = out_avg_q[1];
  assign res_o.avg2      = out_avg_q[2];
  assign res_o.avg3      = out_avg_q[3];
  assign res_o.status    = out_status_q;

  // A rejected compute request skips the window walk entirely.
  `BFM_ASSERT_NEXT(a_err_skips_walk, clk_i, rst_ni, in_fire && is_compute && req_err, st_q == ST_FINISH)
  // A finished result always lands in the output register.
  `BFM_ASSERT_NEXT(a_finish_loads_out, clk_i, rst_ni, out_load, out_valid_q && (st_q == ST_IDLE))
  // Error results carry zero averages.
  `BFM_ASSERT_IMP(a_err_zero_avg, clk_i, rst_ni, out_valid_q && out_status_q, out_avg_q == '0)

endmodule
`default_nettype wire

FILE: verif/box_filter_mipmap_builder_tb.sv
// Self-checking testbench for the box-filter mipmap builder: loads, mip requests, scoreboard.
`timescale 1ns / 100ps
module box_filter_mipmap_builder_tb;
  import bfm_pkg::*;

  localparam int STORE_WORDS = MAX_WIDTH * MAX_HEIGHT;
  // Mismatch lines beyond this count are only counted, not printed.
  localparam int SHOW_LIMIT  = 40;
  // Side of the top-left block of the base image that is loaded first.
  localparam int FILL_SIDE   = 16;

  // One request as it crosses the request channel.
  typedef struct packed {
    op_e        opcode;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [3:0] mip_level;
    logic [7:0] chan0;
    logic [7:0] chan1;
    logic [7:0] chan2;
    logic [7:0] chan3;
  } mip_req_t;

  // One mip pixel as it comes back on the result channel.
  typedef struct packed {
    logic [3:0] level;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] avg0;
    logic [7:0] avg1;
    logic [7:0] avg2;
    logic [7:0] avg3;
    logic       status;
  } mip_res_t;

  // Keeps a private copy of the base image and the registers, works out the
  // mip pixel of every accepted compute request and checks the results in
  // order against it.
  class mip_scoreboard;
    bit [31:0]   pixels [STORE_WORDS];
    bit          written [STORE_WORDS];
    int unsigned img_w = 256;
    int unsigned img_h = 256;
    int unsigned chans = 4;
    int unsigned top   = 8;
    mip_res_t    pending_pixels [$];
    int unsigned n_loads;
    int unsigned n_computes;
    int unsigned n_range_errors;
    int unsigned n_checked;
    int unsigned n_errors;

    function void set_reg(cfg_idx_e idx, logic [8:0] value);
      case (idx)
        CFG_WIDTH:     img_w = value;
        CFG_HEIGHT:    img_h = value;
        CFG_CHANNELS:  chans = value[2:0];
        CFG_TOP_LEVEL: top   = value[3:0];
        default: ;
      endcase
    endfunction

    // True when the request reads no store entry that was never loaded:
    // loads and refused requests read nothing at all.
    function bit window_written(mip_req_t r);
      int unsigned lvl, lim, w, h, side, row, col, yy, xx;
      if (r.opcode == OP_LOAD) return 1'b1;
      lvl = r.mip_level;
      lim = (top < MAX_LEVEL) ? top : MAX_LEVEL;
      w   = (img_w > MAX_WIDTH) ? MAX_WIDTH : img_w;
      h   = (img_h > MAX_HEIGHT) ? MAX_HEIGHT : img_h;
      if (lvl > lim || r.pos_x >= (w >> lvl) || r.pos_y >= (h >> lvl)) return 1'b1;
      side = 1 << lvl;
      for (yy = 0; yy < side; yy++) begin
        row = (32'(r.pos_y) << lvl) + yy;
        for (xx = 0; xx < side; xx++) begin
          col = (32'(r.pos_x) << lvl) + xx;
          if (!written[row * MAX_WIDTH + col]) return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    // Box average of the 2^L by 2^L window, or the range error result.
    function mip_res_t box_average(mip_req_t r);
      mip_res_t    res;
      int unsigned lvl, lim, w, h, side, row, col, addr, yy, xx, c;
      bit [31:0]   word;
      int unsigned sums [4];
      res        = '0;
      res.level  = r.mip_level;
      res.x      = r.pos_x;
      res.y      = r.pos_y;
      res.status = 1'b1;
      lvl = r.mip_level;
      lim = (top < MAX_LEVEL) ? top : MAX_LEVEL;
      w   = (img_w > MAX_WIDTH) ? MAX_WIDTH : img_w;
      h   = (img_h > MAX_HEIGHT) ? MAX_HEIGHT : img_h;
      if (lvl > lim || r.pos_x >= (w >> lvl) || r.pos_y >= (h >> lvl)) return res;
      side = 1 << lvl;
      sums = '{0, 0, 0, 0};
      for (yy = 0; yy < side; yy++) begin
        row = (32'(r.pos_y) << lvl) + yy;
        for (xx = 0; xx < side; xx++) begin
          col  = (32'(r.pos_x) << lvl) + xx;
          addr = row * MAX_WIDTH + col;
          word = (addr < STORE_WORDS) ? pixels[addr] : 32'd0;
          for (c = 0; c < 4; c++) sums[c] += (word >> (8 * c)) & 32'hFF;
        end
      end
      res.avg0   = 8'(sums[0] >> (2 * lvl));
      res.avg1   = 8'(sums[1] >> (2 * lvl));
      res.avg2   = 8'(sums[2] >> (2 * lvl));
      res.avg3   = (chans == 3) ? 8'd0 : 8'(sums[3] >> (2 * lvl));
      res.status = 1'b0;
      return res;
    endfunction

    function void note_request(mip_req_t r);
      mip_res_t    res;
      int unsigned addr;
      if (r.opcode == OP_LOAD) begin
        n_loads++;
        addr = r.pos_y * MAX_WIDTH + r.pos_x;
        if (r.pos_x < MAX_WIDTH && r.pos_y < MAX_HEIGHT) begin
          pixels[addr]  = {r.chan3, r.chan2, r.chan1, r.chan0};
          written[addr] = 1'b1;
        end
      end else begin
        n_computes++;
        res = box_average(r);
        if (res.status) n_range_errors++;
        pending_pixels.push_back(res);
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        n_errors++;
        if (n_errors <= SHOW_LIMIT)
          $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(mip_res_t got);
      mip_res_t want;
      if (pending_pixels.size() == 0) begin
        n_errors++;
        if (n_errors <= SHOW_LIMIT)
          $display("%0t: unexpected result: expected none, got level %0d x %0d y %0d",
                   $time, got.level, got.x, got.y);
        return;
      end
      want = pending_pixels.pop_front();
      n_checked++;
      compare_field("out_level", want.level, got.level);
      compare_field("out_x", want.x, got.x);
      compare_field("out_y", want.y, got.y);
      compare_field("avg0", want.avg0, got.avg0);
      compare_field("avg1", want.avg1, got.avg1);
      compare_field("avg2", want.avg2, got.avg2);
      compare_field("avg3", want.avg3, got.avg3);
      compare_field("status", want.status, got.status);
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [8:0] cfg_data_i;

  bfm_req_if req_if ();
  bfm_res_if res_if ();

  mip_scoreboard sb = new;

  // Idling mix of the current phase, in percent of cycles.
  int unsigned     send_idle_pct;
  int unsigned     recv_stall_pct;
  int unsigned     settings_used;
  longint unsigned cycle_count;
  // The cycle budget grows with every request by a generous multiple of the
  // cycles that request may cost, so a hang is caught soon after it starts.
  longint unsigned cycle_budget;

  box_filter_mipmap_builder u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // The receiver stalls at random in the phases that call for it.
  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Results are sampled at the falling edge: a result that shows valid and
  // ready here is taken at the next rising edge, since nothing changes in
  // between.
  always @(negedge clk_i) begin
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      sb.check_result('{level: res_if.out_level, x: res_if.out_x, y: res_if.out_y,
                        avg0: res_if.avg0, avg1: res_if.avg1, avg2: res_if.avg2,
                        avg3: res_if.avg3, status: res_if.status});
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > cycle_budget) begin
      $display("%0t: run stopped after %0d cycles, %0d results outstanding",
               $time, cycle_count, sb.pending_pixels.size());
      $display("FAIL box_filter_mipmap_builder");
      $finish;
    end
  end

  // A request with every field random; the builders below pin what matters
  // and leave the don't-care fields random so their bits toggle too.
  function automatic mip_req_t random_request();
    mip_req_t r;
    r.opcode    = op_e'($urandom_range(1));
    r.pos_x     = 8'($urandom);
    r.pos_y     = 8'($urandom);
    r.mip_level = 4'($urandom);
    r.chan0     = 8'($urandom);
    r.chan1     = 8'($urandom);
    r.chan2     = 8'($urandom);
    r.chan3     = 8'($urandom);
    return r;
  endfunction

  function automatic mip_req_t load_request(int unsigned x, int unsigned y, logic [31:0] pix);
    mip_req_t r;
    r        = random_request();
    r.opcode = OP_LOAD;
    r.pos_x  = 8'(x);
    r.pos_y  = 8'(y);
    {r.chan3, r.chan2, r.chan1, r.chan0} = pix;
    return r;
  endfunction

  function automatic mip_req_t compute_request(int unsigned lvl, int unsigned x, int unsigned y);
    mip_req_t r;
    r           = random_request();
    r.opcode    = OP_COMPUTE;
    r.mip_level = 4'(lvl);
    r.pos_x     = 8'(x);
    r.pos_y     = 8'(y);
    return r;
  endfunction

  // Presents one request, holds it until the block takes it and notes it in
  // the scoreboard. Valid stays high on return so that back-to-back
  // requests need no second assignment in the same time step.
  task automatic send_request(mip_req_t r);
    int unsigned side;
    side = (r.opcode == OP_COMPUTE && r.mip_level <= MAX_LEVEL) ? (1 << r.mip_level) : 1;
    cycle_budget += 4 * (side * ((side > 4) ? side / 4 : 1) + 4) + 20;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.opcode    <= r.opcode;
    req_if.pos_x     <= r.pos_x;
    req_if.pos_y     <= r.pos_y;
    req_if.mip_level <= r.mip_level;
    req_if.chan0     <= r.chan0;
    req_if.chan1     <= r.chan1;
    req_if.chan2     <= r.chan2;
    req_if.chan3     <= r.chan3;
    @(negedge clk_i);
    while (req_if.ready !== 1'b1) @(negedge clk_i);
    sb.note_request(r);
    @(posedge clk_i);
  endtask

  // Loads every pixel of a level window that was never loaded, so that the
  // request for it reads only defined store entries.
  task automatic fill_window(int unsigned lvl, int unsigned px, int unsigned py);
    int unsigned side, xx, yy, col, row;
    side = 1 << lvl;
    for (yy = 0; yy < side; yy++) begin
      for (xx = 0; xx < side; xx++) begin
        col = (px << lvl) + xx;
        row = (py << lvl) + yy;
        if (!sb.written[row * MAX_WIDTH + col]) send_request(load_request(col, row, $urandom));
      end
    end
  endtask

  // Sender holds off until every expected result is back. Loads give no
  // result, so the task keeps idling after that to let a last load settle
  // before anything touches the registers.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [8:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    sb.set_reg(idx, value);
  endtask

  task automatic apply_settings(logic [8:0] w, logic [8:0] h, logic [2:0] ch, logic [3:0] top);
    drain_results();
    cycle_budget += 100;
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_CHANNELS, ch);
    write_reg(CFG_TOP_LEVEL, top);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    settings_used++;
  endtask

  // Image sizes lean toward the full store and tiny images, with a few
  // values outside the documented range (zero and oversized).
  function automatic logic [8:0] random_dim();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) return 9'd256;
    if (pick < 30) return 9'($urandom_range(4, 1));
    if (pick < 35) return $urandom_range(1) ? 9'd0 : 9'($urandom_range(511, 257));
    return 9'($urandom_range(256, 1));
  endfunction

  // Loads a few pixels inside one mip window, fills the rest of it, then asks
  // for that mip pixel. A broken sequence skips the fill and asks with a level
  // above the limit or a position past the edge of the level instead.
  task automatic run_window_sequence(bit broken);
    int unsigned w, h, lim, fit, lvl, side, px, py, n_touch, pick;
    mip_req_t    r;
    w   = (sb.img_w > MAX_WIDTH) ? MAX_WIDTH : sb.img_w;
    h   = (sb.img_h > MAX_HEIGHT) ? MAX_HEIGHT : sb.img_h;
    lim = (sb.top < MAX_LEVEL) ? sb.top : MAX_LEVEL;
    if (w == 0 || h == 0) begin
      send_request(random_request());
      return;
    end
    // Deepest level that is both allowed and at least one pixel in size.
    fit = 0;
    while (fit < lim && (w >> (fit + 1)) > 0 && (h >> (fit + 1)) > 0) fit++;
    // Windows that are not broken are loaded in full first, so windows stay small.
    pick = $urandom_range(99);
    if (pick < 80) lvl = $urandom_range(2);
    else if (pick < 96) lvl = 3;
    else lvl = 4;
    if (lvl > fit) lvl = $urandom_range(fit);
    side    = 1 << lvl;
    px      = $urandom_range((w >> lvl) - 1);
    py      = $urandom_range((h >> lvl) - 1);
    n_touch = $urandom_range((side * side < 4) ? side * side : 4);
    repeat (n_touch) begin
      send_request(load_request((px << lvl) + $urandom_range(side - 1),
                                (py << lvl) + $urandom_range(side - 1), $urandom));
    end
    if (!broken) fill_window(lvl, px, py);
    r = compute_request(lvl, px, py);
    if (broken) begin
      if ($urandom_range(1) == 1 && (w >> lvl) <= 255) r.pos_x = 8'($urandom_range(255, w >> lvl));
      else r.mip_level = 4'($urandom_range(15, lim + 1));
    end
    send_request(r);
  endtask

  task automatic run_random_phase(int unsigned n_items);
    int unsigned start, pick;
    mip_req_t    r;
    start = sb.n_loads + sb.n_computes;
    while (sb.n_loads + sb.n_computes - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 70) run_window_sequence(1'b0);
      else if (pick < 82) run_window_sequence(1'b1);
      else begin
        // A random request that would read unloaded pixels becomes a load.
        r = random_request();
        if (!sb.window_written(r)) r.opcode = OP_LOAD;
        send_request(r);
      end
      // Now and then the sender waits for every outstanding result.
      if ($urandom_range(199) == 0) drain_results();
    end
  endtask

  initial begin
    int unsigned fx, fy, phase;
    // Every input is known from time zero, with reset asserted at the start.
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = CFG_WIDTH;
    cfg_data_i       = '0;
    req_if.valid     = 1'b0;
    req_if.opcode    = OP_LOAD;
    req_if.pos_x     = '0;
    req_if.pos_y     = '0;
    req_if.mip_level = '0;
    req_if.chan0     = '0;
    req_if.chan1     = '0;
    req_if.chan2     = '0;
    req_if.chan3     = '0;
    res_if.ready     = 1'b0;
    cycle_count      = 0;
    cycle_budget     = 20000;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    settings_used    = 1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The store powers up undefined, so the top-left block of the base
    // image is loaded first for the directed windows below; later windows
    // are loaded before they are asked for.
    for (fy = 0; fy < FILL_SIDE; fy++) begin
      for (fx = 0; fx < FILL_SIDE; fx++) send_request(load_request(fx, fy, $urandom));
    end

    // Reset settings: full 256x256 image, four channels, all levels.
    // A 2x2 window of saturated pixels must average to all ones.
    send_request(load_request(0, 0, 32'hFFFF_FFFF));
    send_request(load_request(1, 0, 32'hFFFF_FFFF));
    send_request(load_request(0, 1, 32'hFFFF_FFFF));
    send_request(load_request(1, 1, 32'hFFFF_FFFF));
    send_request(compute_request(1, 0, 0));
    // Level zero returns the base pixel itself, here at the far corner.
    send_request(load_request(255, 255, 32'h0000_0000));
    send_request(compute_request(0, 255, 255));
    // The widest windows that fit in the loaded block.
    send_request(compute_request(4, 0, 0));
    send_request(compute_request(3, 1, 1));
    // Levels beyond the maximum the block supports.
    send_request(compute_request(9, 0, 0));
    send_request(compute_request(15, 255, 255));
    // Positions just past the edge of level one, in each direction.
    send_request(compute_request(1, 128, 0));
    send_request(compute_request(1, 0, 128));

    // Three channels with a low top level: the fourth average reads zero
    // and one level above the top is refused.
    apply_settings(9'd256, 9'd256, 3'd3, 4'd2);
    send_request(compute_request(2, 0, 0));
    send_request(compute_request(3, 0, 0));

    // Smallest image. A load outside the configured image still lands in
    // the store; it is read back once the image is large again.
    apply_settings(9'd1, 9'd1, 3'd4, 4'd0);
    send_request(load_request(200, 10, 32'hA55A_C33C));
    send_request(compute_request(0, 0, 0));
    send_request(compute_request(1, 0, 0));
    send_request(compute_request(0, 1, 0));

    // Zero width leaves no valid position at all; odd channel codes other
    // than three mean four channels.
    apply_settings(9'd0, 9'd300, 3'd7, 4'd15);
    send_request(compute_request(0, 0, 0));

    // Oversized width and height count as the full store.
    apply_settings(9'd511, 9'd257, 3'd0, 4'd9);
    send_request(compute_request(0, 200, 10));
    send_request(compute_request(0, 255, 255));
    fill_window(1, 127, 127);
    send_request(compute_request(1, 127, 127));
    send_request(compute_request(9, 0, 0));

    // Random part: eight phases, each under fresh register settings (the
    // first at the largest image) and one of four idling mixes, so every
    // mix is seen twice.
    for (phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        apply_settings(9'd256, 9'd256, 3'd4, 4'd8);
      end else begin
        apply_settings(random_dim(), random_dim(),
                       ($urandom_range(99) < 75) ? ($urandom_range(1) ? 3'd3 : 3'd4)
                                                 : 3'($urandom_range(7)),
                       ($urandom_range(99) < 85) ? 4'($urandom_range(8))
                                                 : 4'($urandom_range(15, 9)));
      end
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 49;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 49;
        end
        default: begin
          send_idle_pct  = 38;
          recv_stall_pct = 38;
        end
      endcase
      run_random_phase(185);
    end

    // Wait for the last results, then a little longer for anything stray.
    drain_results();
    cycle_budget += 100;
    repeat (24) @(posedge clk_i);

    $display("Covered %0d pixel loads and %0d mip requests (%0d out of range), %0d checked.",
             sb.n_loads, sb.n_computes, sb.n_range_errors, sb.n_checked);
    $display("Used %0d register settings under four idling mixes; %0d mismatches, %0d left.",
             settings_used, sb.n_errors, sb.pending_pixels.size());
    if (sb.n_errors == 0 && sb.pending_pixels.size() == 0) begin
      $display("PASS box_filter_mipmap_builder");
    end else begin
      $display("FAIL box_filter_mipmap_builder");
    end
    $finish;
  end

endmodule
